// ===== sv/tgafc_pkg.sv =====
// Shared constants, codes and control types for the tile grid area check block.
// No dependencies; every other file but tgafc_ram imports this package.
package tgafc_pkg;

	localparam int TILE_PIXELS = 32;
	localparam int MAX_COLUMNS = 64;
	localparam int MAX_ROWS    = 64;

	localparam int CNT_W  = 7;
	localparam int EDGE_W = 16;
	localparam int POS_W  = 7;
	localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

	// divide by tile size: multiply by reciprocal, then one correction step
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP       = (1 << RECIP_SHIFT) / TILE_PIXELS;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = EDGE_W + RECIP_W;
	localparam int QW          = PROD_W - RECIP_SHIFT;
	localparam int TP_W        = $clog2(TILE_PIXELS + 1);
	localparam int REM_W       = QW + TP_W;

	localparam logic [1:0] MODE_NEW_ROW  = 2'd0;
	localparam logic [1:0] MODE_ADD_TILE = 2'd1;
	localparam logic [1:0] MODE_QUERY    = 2'd2;
	localparam logic [1:0] MODE_READ     = 2'd3;

	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_OUT_OF_MAP   = 3'd1;
	localparam logic [2:0] ST_NO_ROW       = 3'd2;
	localparam logic [2:0] ST_ROW_TOO_LONG = 3'd3;
	localparam logic [2:0] ST_CAPACITY     = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_FIX,
		S_CHK,
		S_SCAN,
		S_DRAIN,
		S_TREAD,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic mul;
		logic fix;
		logic check;
		logic scan_issue;
		logic finish_query;
		logic tread_res;
		logic push;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic query_fail;
		logic query_empty;
		logic scan_last;
	} dp_sts_t;

endpackage

// ===== sv/tgafc_if.sv =====
// Request and response channel interfaces, valid/ready handshake.
// Depends on tgafc_pkg for field widths.
interface tgafc_req_if import tgafc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [1:0]               mode;
	logic                     tile_is_solid;
	logic signed [EDGE_W-1:0] left_edge;
	logic signed [EDGE_W-1:0] top_edge;
	logic signed [EDGE_W-1:0] right_edge;
	logic signed [EDGE_W-1:0] bottom_edge;
	logic [POS_W-1:0]         tile_column;
	logic [POS_W-1:0]         tile_row;

	modport source (
		output valid, mode, tile_is_solid, left_edge, top_edge, right_edge, bottom_edge,
		output tile_column, tile_row,
		input  ready
	);
	modport sink (
		input  valid, mode, tile_is_solid, left_edge, top_edge, right_edge, bottom_edge,
		input  tile_column, tile_row,
		output ready
	);
endinterface

interface tgafc_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic       area_free;
	logic       tile_solid;
	logic       tile_present;

	modport source (
		output valid, status, area_free, tile_solid, tile_present,
		input  ready
	);
	modport sink (
		input  valid, status, area_free, tile_solid, tile_present,
		output ready
	);
endinterface

// ===== sv/tgafc_ram.sv =====
// Generic simple dual-port RAM: masked write port, registered read port.
// No dependencies.
module tgafc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [WIDTH-1:0]                       wmask,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= (mem_q[waddr] & ~wmask) | (wdata & wmask);
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/tgafc_ctrl.sv =====
// Sequencer: accepts words, steps the datapath through a query or tile read.
// Depends on tgafc_pkg (state and command/status types).
module tgafc_ctrl import tgafc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_mode,
	input  dp_sts_t    sts,
	output logic       req_ready,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					case (req_mode)
						MODE_QUERY: state_d = S_MUL;
						MODE_READ:  state_d = S_TREAD;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_FIX;
			end
			S_FIX: begin
				cmd.fix = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				cmd.check = 1'b1;
				state_d   = (sts.query_fail || sts.query_empty) ? S_DONE : S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				cmd.finish_query = 1'b1;
				state_d          = S_DONE;
			end
			S_TREAD: begin
				cmd.tread_res = 1'b1;
				state_d       = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== sv/tgafc_dp.sv =====
// Datapath: grid counters, tile bitmap RAM, edge-to-index divider, row scan, result register.
// Depends on tgafc_pkg and tgafc_ram.
module tgafc_dp import tgafc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	output dp_sts_t                  sts,
	input  logic [1:0]               req_mode,
	input  logic                     req_tile_is_solid,
	input  logic signed [EDGE_W-1:0] req_left_edge,
	input  logic signed [EDGE_W-1:0] req_top_edge,
	input  logic signed [EDGE_W-1:0] req_right_edge,
	input  logic signed [EDGE_W-1:0] req_bottom_edge,
	input  logic [POS_W-1:0]         req_tile_column,
	input  logic [POS_W-1:0]         req_tile_row,
	input  logic                     rsp_ready,
	output logic                     rsp_valid,
	output logic [2:0]               rsp_status,
	output logic                     rsp_area_free,
	output logic                     rsp_tile_solid,
	output logic                     rsp_tile_present
);

	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
	localparam logic [TP_W-1:0]    TP_C    = TP_W'(TILE_PIXELS);

	// grid counters
	logic [CNT_W-1:0] col_cnt_q, row_cnt_q, fill_cnt_q, row_m1;
	logic             inc_row, inc_col, inc_fill;
	logic [2:0]       ld_status;

	// bitmap RAM
	logic                   ram_we;
	logic [ROW_AW-1:0]      ram_waddr, ram_raddr;
	logic [MAX_COLUMNS-1:0] ram_wdata, ram_wmask, ram_rdata;

	// item capture
	logic [EDGE_W-1:0] edge_q [4];
	logic [POS_W-1:0]  col_q, row_q;

	// divider lanes: 0 left, 1 top, 2 right, 3 bottom
	logic [EDGE_W-1:0]       mag_c [4];
	logic [EDGE_W-1:0]       mag_s1 [4];
	logic                    neg_s1 [4];
	logic [PROD_W-1:0]       prod_s1 [4];
	logic [QW-1:0]           q0_c [4];
	logic [REM_W-1:0]        chk_c [4];
	logic [REM_W-1:0]        rem_c [4];
	logic [QW-1:0]           q_c [4];
	logic signed [QW-1:0]    idx_c [4];
	logic signed [QW-1:0]    idx_s2 [4];

	// scan
	logic [MAX_COLUMNS-1:0] mask_c, mask_q;
	logic [CNT_W-1:0]       ptr_q, br_q;
	logic                   rd_vld_s1, hit_q, row_hit;
	logic                   rd_present;

	// result staging and output register
	logic [2:0] res_status_q;
	logic       res_free_q, res_solid_q, res_present_q;
	logic       out_vld_q;

	tgafc_ram #(
		.WIDTH(MAX_COLUMNS),
		.DEPTH(MAX_ROWS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.wmask(ram_wmask),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign row_m1 = row_cnt_q - 1'b1;

	// load ops act on the live request in the accept cycle; a new row is cleared as it opens
	always_comb begin
		ld_status = ST_OK;
		ram_we    = 1'b0;
		ram_waddr = row_cnt_q[ROW_AW-1:0];
		ram_wmask = '1;
		ram_wdata = '0;
		inc_row   = 1'b0;
		inc_col   = 1'b0;
		inc_fill  = 1'b0;
		if (cmd.accept) begin
			case (req_mode)
				MODE_NEW_ROW: begin
					if (row_cnt_q >= CNT_W'(MAX_ROWS)) begin
						ld_status = ST_CAPACITY;
					end else begin
						ram_we  = 1'b1;
						inc_row = 1'b1;
					end
				end
				MODE_ADD_TILE: begin
					ram_waddr = row_m1[ROW_AW-1:0];
					ram_wmask = MAX_COLUMNS'(1) << fill_cnt_q[COL_AW-1:0];
					ram_wdata = {MAX_COLUMNS{req_tile_is_solid}};
					if (row_cnt_q == '0) begin
						ld_status = ST_NO_ROW;
					end else if (row_cnt_q == CNT_W'(1)) begin
						if (col_cnt_q >= CNT_W'(MAX_COLUMNS)) begin
							ld_status = ST_CAPACITY;
						end else begin
							ram_we   = 1'b1;
							inc_col  = 1'b1;
							inc_fill = 1'b1;
						end
					end else if (fill_cnt_q >= col_cnt_q) begin
						ld_status = ST_ROW_TOO_LONG;
					end else begin
						ram_we   = 1'b1;
						inc_fill = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign ram_raddr = (cmd.accept) ? req_tile_row[ROW_AW-1:0] : ptr_q[ROW_AW-1:0];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag_c[i] = edge_q[i][EDGE_W-1] ? (~edge_q[i] + 1'b1) : edge_q[i];
			q0_c[i]  = prod_s1[i][PROD_W-1:RECIP_SHIFT];
			chk_c[i] = REM_W'(q0_c[i]) * REM_W'(TP_C);
			rem_c[i] = REM_W'(mag_s1[i]) - chk_c[i];
			q_c[i]   = (rem_c[i] >= REM_W'(TP_C)) ? (q0_c[i] + 1'b1) : q0_c[i];
			idx_c[i] = neg_s1[i] ? -signed'(q_c[i]) : signed'(q_c[i]);
		end
	end

	always_comb begin
		for (int c = 0; c < MAX_COLUMNS; c++) begin
			mask_c[c] = (signed'(QW'(c)) >= idx_s2[0]) && (signed'(QW'(c)) <= idx_s2[2]);
		end
	end

	assign sts.query_fail  = idx_s2[0][QW-1] || idx_s2[1][QW-1] ||
		(idx_s2[2] >= signed'(QW'(col_cnt_q))) || (idx_s2[3] >= signed'(QW'(row_cnt_q)));
	assign sts.query_empty = (idx_s2[1] > idx_s2[3]) || (idx_s2[0] > idx_s2[2]);
	assign sts.scan_last   = (ptr_q == br_q);
	assign sts.out_free    = !out_vld_q || rsp_ready;

	assign row_hit    = rd_vld_s1 && (|(ram_rdata & mask_q));
	assign rd_present = (row_q < POS_W'(row_cnt_q)) && (col_q < POS_W'(col_cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q  <= '0;
			row_cnt_q  <= '0;
			fill_cnt_q <= '0;
			rd_vld_s1  <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (inc_row) begin
				row_cnt_q  <= row_cnt_q + 1'b1;
				fill_cnt_q <= '0;
			end
			if (inc_fill) begin
				fill_cnt_q <= fill_cnt_q + 1'b1;
			end
			if (inc_col) begin
				col_cnt_q <= col_cnt_q + 1'b1;
			end
			rd_vld_s1 <= cmd.scan_issue;
			if (cmd.push) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			edge_q[0]     <= req_left_edge;
			edge_q[1]     <= req_top_edge;
			edge_q[2]     <= req_right_edge;
			edge_q[3]     <= req_bottom_edge;
			col_q         <= req_tile_column;
			row_q         <= req_tile_row;
			res_status_q  <= ld_status;
			res_free_q    <= 1'b0;
			res_solid_q   <= 1'b0;
			res_present_q <= 1'b0;
		end
		if (cmd.mul) begin
			for (int i = 0; i < 4; i++) begin
				neg_s1[i]  <= edge_q[i][EDGE_W-1];
				mag_s1[i]  <= mag_c[i];
				prod_s1[i] <= PROD_W'(mag_c[i]) * PROD_W'(RECIP_C);
			end
		end
		if (cmd.fix) begin
			for (int i = 0; i < 4; i++) begin
				idx_s2[i] <= idx_c[i];
			end
		end
		if (cmd.check) begin
			mask_q     <= mask_c;
			ptr_q      <= idx_s2[1][CNT_W-1:0];
			br_q       <= idx_s2[3][CNT_W-1:0];
			hit_q      <= 1'b0;
			if (sts.query_fail) begin
				res_status_q <= ST_OUT_OF_MAP;
				res_free_q   <= 1'b0;
			end else begin
				res_status_q <= ST_OK;
				res_free_q   <= 1'b1;
			end
		end else if (row_hit) begin
			hit_q <= 1'b1;
		end
		if (cmd.scan_issue) begin
			ptr_q <= ptr_q + 1'b1;
		end
		if (cmd.finish_query) begin
			res_status_q <= ST_OK;
			res_free_q   <= !(hit_q || row_hit);
		end
		if (cmd.tread_res) begin
			res_status_q  <= ST_OK;
			res_present_q <= rd_present;
			res_solid_q   <= rd_present && ram_rdata[col_q[COL_AW-1:0]];
		end
		if (cmd.push) begin
			rsp_status       <= res_status_q;
			rsp_area_free    <= res_free_q;
			rsp_tile_solid   <= res_solid_q;
			rsp_tile_present <= res_present_q;
		end
	end

	assign rsp_valid = out_vld_q;

endmodule

// ===== sv/tile_grid_area_free_check_core.sv =====
// Tile grid with area-free query: every request word yields exactly one response word.
// A scanning query reads its rows from top to bottom; the bitmap RAM gives one row word per
// cycle. A row is zeroed in the RAM when it is opened, so no clearing pass follows reset.
// The next request is taken while a response waits in the output register.
// Depends on tgafc_pkg, tgafc_if, tgafc_ctrl, tgafc_dp, tgafc_ram.
module tile_grid_area_free_check_core import tgafc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	tgafc_req_if.sink          req,
	tgafc_rsp_if.source        rsp
);

	dp_cmd_t    cmd;
	dp_sts_t    sts;
	logic       rsp_valid, rsp_area_free, rsp_tile_solid, rsp_tile_present;
	logic [2:0] rsp_status;

	tgafc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_mode (req.mode),
		.sts      (sts),
		.req_ready(req.ready),
		.cmd      (cmd)
	);

	tgafc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.req_mode         (req.mode),
		.req_tile_is_solid(req.tile_is_solid),
		.req_left_edge    (req.left_edge),
		.req_top_edge     (req.top_edge),
		.req_right_edge   (req.right_edge),
		.req_bottom_edge  (req.bottom_edge),
		.req_tile_column  (req.tile_column),
		.req_tile_row     (req.tile_row),
		.rsp_ready        (rsp.ready),
		.rsp_valid        (rsp_valid),
		.rsp_status       (rsp_status),
		.rsp_area_free    (rsp_area_free),
		.rsp_tile_solid   (rsp_tile_solid),
		.rsp_tile_present (rsp_tile_present)
	);

	assign rsp.valid        = rsp_valid;
	assign rsp.status       = rsp_status;
	assign rsp.area_free    = rsp_area_free;
	assign rsp.tile_solid   = rsp_tile_solid;
	assign rsp.tile_present = rsp_tile_present;

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while previous word still in work");

	a_free_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.area_free) |-> (rsp.status == ST_OK))
		else $error("area_free set on a failed response");

	a_solid_needs_present: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.tile_solid) |-> rsp.tile_present)
		else $error("tile_solid without tile_present");

	a_push_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> sts.out_free)
		else $error("response register overwritten");
`endif

endmodule
